// ===== hw/rtl/kwm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared widths, defaults and result codes for the k-way sorted merge unit.
// ----------------------------------------------------------------------------
package kwm_pkg;

    localparam int LANES_DEF     = 8;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int LANE_W  = 3;
    localparam int VALUE_W = 32;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] LANES_IN_USE_RST = 4'd8;

    typedef enum logic [1:0] {
        KIND_VALUE  = 2'd0,
        KIND_FINAL  = 2'd1,
        KIND_REJECT = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    typedef enum logic [0:0] {
        ACT_PUSH   = 1'b0,
        ACT_FINISH = 1'b1
    } t_action;

endpackage

// ===== hw/rtl/kwm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_if
// Handshake channels of the merge unit: input items, result items, config.
// ----------------------------------------------------------------------------
interface kwm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [kwm_pkg::LANE_W-1:0]  lane;
    logic signed [kwm_pkg::VALUE_W-1:0] value;
    logic                        final_of_lane;

    modport source (output valid, action, lane, value, final_of_lane, input ready);
    modport sink   (input valid, action, lane, value, final_of_lane, output ready);
endinterface

interface kwm_out_if;
    logic                        valid;
    logic                        ready;
    kwm_pkg::t_kind              kind;
    logic signed [kwm_pkg::VALUE_W-1:0] merged_value;
    logic [kwm_pkg::LANE_W-1:0]  source_lane;
    logic [kwm_pkg::LANE_W-1:0]  next_lane;

    modport source (output valid, kind, merged_value, source_lane, next_lane, input ready);
    modport sink   (input valid, kind, merged_value, source_lane, next_lane, output ready);
endinterface

interface kwm_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [kwm_pkg::CFG_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ===== hw/rtl/k_way_sorted_merge_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_way_sorted_merge_unit
// Merges up to LANES ascending key streams into one ascending stream.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the result side stalls: the item is caught
// in an input register, then checked, written into its lane's head slot and
// the smallest head picked by a comparator tree over all LANES heads into the
// result register. That tree (log2(LANES) signed compares of KEY_WIDTH bits)
// sets the clock. Pushes and finish marks completing a round emit the smallest
// head and name the lane to feed next; a rejected item returns kind REJECT and
// changes nothing. Config is to be written when idle; the block does not check.
module k_way_sorted_merge_unit #(
    parameter int LANES     = kwm_pkg::LANES_DEF,
    parameter int KEY_WIDTH = kwm_pkg::KEY_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kwm_in_if.sink      i_in,
    kwm_out_if.source   o_out,
    kwm_cfg_if.sink     i_cfg
);

    localparam int LW = $clog2(LANES);
    localparam int P  = 1 << LW;
    localparam int CW = 7;

    logic [kwm_pkg::CFG_W-1:0] r_lanes;

    logic                          r_in_valid;
    logic                          r_action;
    logic [kwm_pkg::LANE_W-1:0]    r_lane;
    logic signed [kwm_pkg::VALUE_W-1:0] r_value;
    logic                          r_fin;

    logic [KEY_WIDTH-1:0] r_head [LANES];
    logic [LANES-1:0]     r_full, r_done;
    logic [LANES-1:0]     n_full, n_done;

    logic                          r_out_valid;
    kwm_pkg::t_kind                r_kind, n_kind;
    logic [kwm_pkg::VALUE_W-1:0]   r_merged, n_merged;
    logic [kwm_pkg::LANE_W-1:0]    r_src, n_src, r_next, n_next;
    logic                          n_has_result;

    logic advance;
    logic in_acc;

    logic [CW-1:0]        used, cfg_ext;
    logic [LANES-1:0]     in_use, sel, full_w, done_w, pend, best_sel, full_after;
    logic                 bad, is_push, any_left;
    logic [KEY_WIDTH-1:0] key_in;
    logic [KEY_WIDTH-1:0] head_w [LANES];
    logic [63:0]          key_ext, merged_ext;

    logic                 nd_valid [2*P];
    logic [KEY_WIDTH-1:0] nd_key   [2*P];
    logic [LW-1:0]        nd_idx   [2*P];

    function automatic logic [kwm_pkg::LANE_W-1:0] next_needed(
        input logic [LANES-1:0] use_v,
        input logic [LANES-1:0] full_v,
        input logic [LANES-1:0] done_v
    );
        logic [kwm_pkg::LANE_W-1:0] res;
        logic                       found;
        res   = '0;
        found = 1'b0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (use_v[i] && done_v[i]) begin
                res = kwm_pkg::LANE_W'(i);
            end
        end
        for (int i = LANES - 1; i >= 0; i--) begin
            if (use_v[i] && !full_v[i] && !done_v[i]) begin
                res   = kwm_pkg::LANE_W'(i);
                found = 1'b1;
            end
        end
        return found ? res : res;
    endfunction

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_kind;
    assign o_out.merged_value = r_merged;
    assign o_out.source_lane  = r_src;
    assign o_out.next_lane    = r_next;

    always_comb begin
        cfg_ext = {3'b000, r_lanes};
        if (cfg_ext == '0) begin
            used = CW'(1);
        end else if (cfg_ext > CW'(LANES)) begin
            used = CW'(LANES);
        end else begin
            used = cfg_ext;
        end
    end

    assign key_ext = 64'(r_value);
    assign key_in  = key_ext[KEY_WIDTH-1:0];
    assign is_push = (r_action == kwm_pkg::ACT_PUSH);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            in_use[i] = CW'(i) < used;
            sel[i]    = {4'b0000, r_lane} == CW'(i);
        end
        bad = !(|(sel & in_use));
        if (is_push && (|(sel & (r_full | r_done)))) begin
            bad = 1'b1;
        end
        full_w = is_push ? (r_full | sel) : r_full;
        done_w = (is_push && !r_fin) ? r_done : (r_done | sel);
        for (int i = 0; i < LANES; i++) begin
            head_w[i] = (is_push && sel[i]) ? key_in : r_head[i];
        end
        pend = in_use & ~full_w & ~done_w;
    end

    // min tree, lower lane on the left so ties keep it
    always_comb begin
        for (int i = 0; i < P; i++) begin
            if (i < LANES) begin
                nd_valid[P+i] = full_w[i] && in_use[i];
                nd_key[P+i]   = head_w[i];
            end else begin
                nd_valid[P+i] = 1'b0;
                nd_key[P+i]   = '0;
            end
            nd_idx[P+i] = LW'(i);
        end
        nd_valid[0] = 1'b0;
        nd_key[0]   = '0;
        nd_idx[0]   = '0;
        for (int k = P - 1; k >= 1; k--) begin
            if (nd_valid[2*k+1] && (!nd_valid[2*k] ||
                    ($signed(nd_key[2*k+1]) < $signed(nd_key[2*k])))) begin
                nd_valid[k] = 1'b1;
                nd_key[k]   = nd_key[2*k+1];
                nd_idx[k]   = nd_idx[2*k+1];
            end else begin
                nd_valid[k] = nd_valid[2*k];
                nd_key[k]   = nd_key[2*k];
                nd_idx[k]   = nd_idx[2*k];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            best_sel[i] = nd_valid[1] && (nd_idx[1] == LW'(i));
        end
        full_after = full_w & ~best_sel;
        any_left   = |(in_use & (full_after | ~done_w));
        merged_ext = 64'(nd_key[1]);

        n_has_result = 1'b1;
        n_kind       = kwm_pkg::KIND_VALUE;
        n_merged     = '0;
        n_src        = '0;
        n_next       = '0;
        n_full       = r_full;
        n_done       = r_done;
        if (bad) begin
            n_kind = kwm_pkg::KIND_REJECT;
            n_next = next_needed(in_use, r_full, r_done);
        end else if (|pend) begin
            n_has_result = 1'b0;
            n_full       = full_w;
            n_done       = done_w;
        end else if (!nd_valid[1]) begin
            n_kind = kwm_pkg::KIND_EMPTY;
            n_full = '0;
            n_done = '0;
        end else begin
            n_merged = merged_ext[kwm_pkg::VALUE_W-1:0];
            n_src    = kwm_pkg::LANE_W'(nd_idx[1]);
            if (!any_left) begin
                n_kind = kwm_pkg::KIND_FINAL;
                n_full = '0;
                n_done = '0;
            end else begin
                n_kind = kwm_pkg::KIND_VALUE;
                n_next = next_needed(in_use, full_after, done_w);
                n_full = full_after;
                n_done = done_w;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes     <= kwm_pkg::LANES_IN_USE_RST;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_full      <= '0;
            r_done      <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_lanes <= i_cfg.data;
            end
            r_in_valid <= in_acc || (r_in_valid && !advance);
            if (advance) begin
                r_out_valid <= n_has_result;
                r_full      <= n_full;
                r_done      <= n_done;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_in.action;
            r_lane   <= i_in.lane;
            r_value  <= i_in.value;
            r_fin    <= i_in.final_of_lane;
        end
        if (advance) begin
            r_kind   <= n_kind;
            r_merged <= n_merged;
            r_src    <= n_src;
            r_next   <= n_next;
            if (!bad && is_push) begin
                for (int i = 0; i < LANES; i++) begin
                    if (sel[i]) begin
                        r_head[i] <= key_in;
                    end
                end
            end
        end
    end

endmodule

// ===== hw/rtl/kwm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_checker
// Port-level checks on the merge unit's result channel, bound to the top.
// ----------------------------------------------------------------------------
module kwm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input kwm_pkg::t_kind                i_kind,
    input logic [kwm_pkg::VALUE_W-1:0]   i_merged_value,
    input logic [kwm_pkg::LANE_W-1:0]    i_source_lane,
    input logic [kwm_pkg::LANE_W-1:0]    i_next_lane
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_kind) && $stable(i_merged_value) &&
            $stable(i_source_lane) && $stable(i_next_lane))
        else $error("result item changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_end_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == kwm_pkg::KIND_FINAL || i_kind == kwm_pkg::KIND_EMPTY)
            |-> i_next_lane == '0)
        else $error("end of merge names a next lane");

    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == kwm_pkg::KIND_REJECT || i_kind == kwm_pkg::KIND_EMPTY)
            |-> i_merged_value == '0 && i_source_lane == '0)
        else $error("reject or empty item carries data");

endmodule

bind k_way_sorted_merge_unit kwm_checker u_kwm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_kind         (o_out.kind),
    .i_merged_value (o_out.merged_value),
    .i_source_lane  (o_out.source_lane),
    .i_next_lane    (o_out.next_lane)
);

// ===== dv/kwm_merge_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_merge_checker
// Watches the input, result and config channels of the merge unit. It keeps
// its own copy of the head slots and lane flags, works out the result of each
// accepted item and compares every accepted result field by field. It also
// tells the stimulus which lane the merge needs next.
// ----------------------------------------------------------------------------
module kwm_merge_checker
    import kwm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    kwm_in_if                   i_in_ch,
    kwm_out_if                  i_out_ch,
    kwm_cfg_if                  i_cfg_ch,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_merges_done,
    output logic [LANE_W-1:0]   o_feed_lane,
    output logic                o_feed_drain
);

    typedef struct packed {
        t_kind                     kind;
        logic signed [VALUE_W-1:0] merged_value;
        logic [LANE_W-1:0]         source_lane;
        logic [LANE_W-1:0]         next_lane;
    } merge_out_t;

    logic [CFG_W-1:0]          lanes_cfg;
    logic signed [VALUE_W-1:0] head_key [LANES_DEF];
    logic                      head_full [LANES_DEF];
    logic                      lane_done [LANES_DEF];
    merge_out_t                merge_out_q [$];

    function automatic int unsigned used_count();
        int unsigned n;
        n = lanes_cfg;
        if (n < 1) n = 1;
        if (n > LANES_DEF) n = LANES_DEF;
        return n;
    endfunction

    function automatic logic [LANE_W-1:0] wanted_lane(input int unsigned used);
        for (int i = 0; i < used; i++)
            if (!head_full[i] && !lane_done[i]) return i[LANE_W-1:0];
        for (int i = 0; i < used; i++)
            if (lane_done[i]) return i[LANE_W-1:0];
        return '0;
    endfunction

    function automatic void clear_lanes();
        for (int i = 0; i < LANES_DEF; i++) begin
            head_full[i] = 1'b0;
            lane_done[i] = 1'b0;
        end
    endfunction

    // Returns 1 when the item yields a result.
    function automatic bit merge_step(input t_action act, input logic [LANE_W-1:0] lane,
                                      input logic signed [VALUE_W-1:0] key, input logic fin,
                                      output merge_out_t res);
        int unsigned used;
        int          best;
        bit          bad;
        bit          any_left;
        used = used_count();
        res.kind = KIND_VALUE;
        res.merged_value = '0;
        res.source_lane = '0;
        res.next_lane = '0;
        bad = (lane >= used);
        if (!bad && act == ACT_PUSH) bad = head_full[lane] || lane_done[lane];
        if (bad) begin
            res.kind = KIND_REJECT;
            res.next_lane = wanted_lane(used);
            return 1;
        end
        if (act == ACT_PUSH) begin
            head_key[lane] = key;
            head_full[lane] = 1'b1;
            if (fin) lane_done[lane] = 1'b1;
        end else begin
            lane_done[lane] = 1'b1;
        end
        for (int i = 0; i < used; i++)
            if (!head_full[i] && !lane_done[i]) return 0;
        best = -1;
        for (int i = 0; i < used; i++)
            if (head_full[i] && (best < 0 || head_key[i] < head_key[best])) best = i;
        if (best < 0) begin
            res.kind = KIND_EMPTY;
            clear_lanes();
            return 1;
        end
        head_full[best] = 1'b0;
        res.merged_value = head_key[best];
        res.source_lane = best[LANE_W-1:0];
        any_left = 1'b0;
        for (int i = 0; i < used; i++)
            if (head_full[i] || !lane_done[i]) any_left = 1'b1;
        if (!any_left) begin
            res.kind = KIND_FINAL;
            clear_lanes();
        end else begin
            res.next_lane = wanted_lane(used);
        end
        return 1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_merges_done = 0;
        o_feed_lane = '0;
        o_feed_drain = 1'b0;
    end

    always @(posedge i_clk) begin
        merge_out_t res;
        merge_out_t want;
        if (!i_rst_n) begin
            lanes_cfg = LANES_IN_USE_RST;
            clear_lanes();
            merge_out_q.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (merge_step(t_action'(i_in_ch.action), i_in_ch.lane, i_in_ch.value,
                               i_in_ch.final_of_lane, res)) begin
                    merge_out_q.push_back(res);
                    if (res.kind == KIND_FINAL || res.kind == KIND_EMPTY) o_merges_done++;
                end
            end
            if (i_cfg_ch.valid && i_cfg_ch.ready) lanes_cfg = i_cfg_ch.data;
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (merge_out_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result, kind %0d value %0d",
                                              i_out_ch.kind, i_out_ch.merged_value));
                end else begin
                    want = merge_out_q.pop_front();
                    if (i_out_ch.kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d",
                                                  i_out_ch.kind, want.kind));
                    if (i_out_ch.merged_value !== want.merged_value)
                        report_mismatch($sformatf("merged_value %0d, want %0d",
                                                  i_out_ch.merged_value, want.merged_value));
                    if (i_out_ch.source_lane !== want.source_lane)
                        report_mismatch($sformatf("source_lane %0d, want %0d",
                                                  i_out_ch.source_lane, want.source_lane));
                    if (i_out_ch.next_lane !== want.next_lane)
                        report_mismatch($sformatf("next_lane %0d, want %0d",
                                                  i_out_ch.next_lane, want.next_lane));
                end
            end
        end
        o_pending = merge_out_q.size();
        o_feed_lane = wanted_lane(used_count());
        o_feed_drain = lane_done[o_feed_lane];
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the merge unit testbench. Runs a short directed sequence over the
// corner cases, then random merges with random lane counts, ascending keys
// and some stray items, with bursty input, a stalling output side, one long
// output hold-off and pauses until the result queue drains.
// ----------------------------------------------------------------------------
module tb;
    import kwm_pkg::*;

    localparam int ITEMS       = 1650;
    localparam int HOLD_CYCLES = 100;
    localparam int SETTLE      = 4;

    logic i_clk;
    logic i_rst_n;

    kwm_in_if  in_ch ();
    kwm_out_if out_ch ();
    kwm_cfg_if cfg_ch ();

    int                fail_count;
    int                pending;
    int                merges_done;
    logic [LANE_W-1:0] feed_lane;
    logic              feed_drain;

    bit hold_req;
    bit gaps_on;
    bit pause_on;
    bit pause_next;
    int burst_left;
    int items_sent;

    k_way_sorted_merge_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    kwm_merge_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_ch       (in_ch),
        .i_out_ch      (out_ch),
        .i_cfg_ch      (cfg_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_merges_done (merges_done),
        .o_feed_lane   (feed_lane),
        .o_feed_drain  (feed_drain)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Result side: stall patterns, plus one long hold-off on request.
    initial begin
        int unsigned hold_left;
        int unsigned cyc;
        int unsigned mode;
        out_ch.ready = 1'b0;
        hold_left = 0;
        cyc = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 128 == 0) mode = $urandom_range(0, 3);
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (cyc % 3 == 0);
                endcase
            end
        end
    end

    // Called just after a falling edge; returns at the accepting rising edge.
    task automatic offer_now(input t_action act, input logic [LANE_W-1:0] lane,
                             input logic signed [VALUE_W-1:0] val, input logic fin);
        int unsigned waits;
        bit          pause;
        waits = 0;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) waits = $urandom_range(1, 6);
        end
        pause = pause_next || (pause_on && $urandom_range(0, 79) == 0);
        pause_next = 1'b0;
        if (pause && waits == 0) waits = 1;
        if (waits != 0) begin
            in_ch.valid <= 1'b0;
            repeat (waits) @(negedge i_clk);
            if (pause) while (pending != 0) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.lane          <= lane;
        in_ch.value         <= val;
        in_ch.final_of_lane <= fin;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        items_sent++;
    endtask

    task automatic offer(input t_action act, input logic [LANE_W-1:0] lane,
                         input logic signed [VALUE_W-1:0] val, input logic fin);
        @(negedge i_clk);
        offer_now(act, lane, val, fin);
    endtask

    task automatic write_lanes(input logic [CFG_W-1:0] n);
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= n;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One merge with ascending keys per lane, fed in the order the merge asks.
    task automatic run_merge(input int min_len, input int max_len, input int noise_pct,
                             input int pause_at);
        int     left [LANES_DEF];
        longint tail [LANES_DEF];
        int     start;
        int     n;
        int     s;
        longint v;
        logic   fin;
        logic [LANE_W-1:0] lane;
        start = merges_done;
        n = 0;
        for (int l = 0; l < LANES_DEF; l++) begin
            left[l] = $urandom_range(min_len, max_len);
            if ($urandom_range(0, 2) == 0) s = $urandom_range(0, 6) - 3;
            else s = $urandom;
            tail[l] = s;
        end
        forever begin
            @(negedge i_clk);
            if (merges_done != start) break;
            n++;
            if (n == pause_at) pause_next = 1'b1;
            lane = feed_lane;
            if ($urandom_range(0, 99) < noise_pct) begin
                offer_now(t_action'($urandom_range(0, 1)), LANE_W'($urandom_range(0, 7)),
                          $urandom, 1'($urandom_range(0, 1)));
            end else if (feed_drain || left[lane] == 0) begin
                offer_now(ACT_FINISH, lane, $urandom, 1'($urandom_range(0, 1)));
            end else begin
                case ($urandom_range(0, 3))
                    0: v = tail[lane];
                    1: v = tail[lane] + $urandom_range(1, 3);
                    2: v = tail[lane] + $urandom_range(0, 65536);
                    default: v = tail[lane] + longint'($urandom);
                endcase
                if (v > 64'sd2147483647) v = 64'sd2147483647;
                tail[lane] = v;
                left[lane]--;
                fin = (left[lane] == 0) && ($urandom_range(0, 1) == 1);
                offer_now(ACT_PUSH, lane, v[VALUE_W-1:0], fin);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    initial begin
        int k;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.lane = '0;
        in_ch.value = '0;
        in_ch.final_of_lane = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        gaps_on = 1'b1;
        pause_on = 1'b0;
        pause_next = 1'b0;
        burst_left = 0;
        items_sent = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Three lanes: rejects, key extremes, drain through a finished lane,
        // merge that ends empty after emitting.
        write_lanes(4'd3);
        offer(ACT_PUSH,   3'd5, 32'sd0, 1'b0);
        offer(ACT_PUSH,   3'd0, 32'sh7fffffff, 1'b0);
        offer(ACT_PUSH,   3'd0, 32'sd1, 1'b0);
        offer(ACT_PUSH,   3'd1, 32'sh80000000, 1'b1);
        offer(ACT_PUSH,   3'd1, 32'sd0, 1'b0);
        offer(ACT_FINISH, 3'd2, 32'sd0, 1'b0);
        offer(ACT_FINISH, 3'd7, 32'sd0, 1'b0);
        offer(ACT_FINISH, 3'd1, 32'sd0, 1'b0);
        offer(ACT_FINISH, 3'd0, 32'sd0, 1'b0);
        // Ties, finish mark on a lane holding a head, final flag.
        offer(ACT_PUSH,   3'd2, 32'sd4, 1'b0);
        offer(ACT_FINISH, 3'd2, 32'sd0, 1'b0);
        offer(ACT_PUSH,   3'd1, 32'sd4, 1'b1);
        offer(ACT_PUSH,   3'd0, 32'sd4, 1'b0);
        offer(ACT_FINISH, 3'd0, 32'sd0, 1'b0);
        offer(ACT_FINISH, 3'd0, 32'sd0, 1'b0);
        // Zero lanes counts as one.
        write_lanes(4'd0);
        offer(ACT_PUSH,   3'd1, 32'sd3, 1'b0);
        offer(ACT_PUSH,   3'd0, -32'sd1, 1'b0);
        offer(ACT_PUSH,   3'd0, 32'sd5, 1'b1);
        offer(ACT_FINISH, 3'd0, 32'sd0, 1'b0);

        // Long output hold-off with the input running flat out, then a pause
        // mid-merge until every result is out.
        write_lanes(4'd2);
        gaps_on = 1'b0;
        hold_req = 1'b1;
        run_merge(40, 40, 0, 60);

        k = 0;
        while (items_sent < ITEMS) begin
            if (k % 3 == 0) begin
                case (k / 3)
                    0: write_lanes(4'd15);
                    1: write_lanes(4'd1);
                    2: write_lanes(4'd8);
                    3: write_lanes(4'd0);
                    default: write_lanes(CFG_W'($urandom_range(0, 15)));
                endcase
            end
            gaps_on = ($urandom_range(0, 9) < 7);
            pause_on = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 4) != 0) run_merge(0, 4, 10, -1);
            else run_merge(0, 12, 10, -1);
            k++;
        end

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
